// ----- rtl/csre_pkg.sv -----
package csre_pkg;

  // Ring geometry
  localparam int MAX_ITEMS = 64;
  localparam int LEN_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 7;
  localparam int TURN_W    = 6;
  localparam int TOTAL_W   = 12;
  localparam int REMAIN_W  = 7;
  localparam int COUNT_W   = 7;

  // Ring length after reset: 64 values, or fewer if the ring is shorter
  localparam int RESET_LEN = (MAX_ITEMS < 64) ? MAX_ITEMS : 64;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Item modes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [VAL_W-1:0] target_value;
  } item_t;

  typedef struct packed {
    logic                found;
    logic                rotate_right;
    logic [TURN_W-1:0]   rotations;
    logic [TOTAL_W-1:0]  total_rotations;
    logic [REMAIN_W-1:0] remaining;
  } result_t;

  typedef enum logic [1:0] {
    RING_HOLD,
    RING_LOAD,
    RING_ROTATE,
    RING_REMOVE
  } ring_op_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_FILL,
    CELL_CLEAR,
    CELL_NEXT,
    CELL_HEAD
  } cell_op_t;

  // Command from the controller to the row of cells; bound is the load
  // count for a load and the current ring length for a turn or a removal
  typedef struct packed {
    ring_op_t         op;
    logic [LEN_W-1:0] bound;
  } ring_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

endpackage

// ----- rtl/csre_cell.sv -----
module csre_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  csre_pkg::cell_op_t          op,
  input  logic [csre_pkg::VAL_W-1:0]  init_value,
  input  logic [csre_pkg::VAL_W-1:0]  fill_value,
  input  logic [csre_pkg::VAL_W-1:0]  next_value,
  input  logic [csre_pkg::VAL_W-1:0]  head_value,
  output logic [csre_pkg::VAL_W-1:0]  value
);
  import csre_pkg::*;

  // Hold one ring slot; take the neighbor, the head, a fill value or zero
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= init_value;
    end else begin
      unique case (op)
        CELL_HOLD:  value <= value;
        CELL_FILL:  value <= fill_value;
        CELL_CLEAR: value <= '0;
        CELL_NEXT:  value <= next_value;
        CELL_HEAD:  value <= head_value;
        default:    value <= value;
      endcase
    end
  end

endmodule

// ----- rtl/csre_ring.sv -----
module csre_ring (
  input  logic                        clk,
  input  logic                        rst,
  input  csre_pkg::ring_cmd_t         cmd,
  output logic [csre_pkg::VAL_W-1:0]  head_value
);
  import csre_pkg::*;

  logic [VAL_W-1:0] value [MAX_ITEMS];

  assign head_value = value[0];

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_op_t         op;
    logic [VAL_W-1:0] next_value;
    logic             inside_ring;
    logic             last_slot;

    // Slot position against the load count or the ring length
    assign inside_ring = (LEN_W'(i) < cmd.bound);
    assign last_slot   = (LEN_W'(i + 1) == cmd.bound);

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_value = '0;
    end else begin : g_link
      assign next_value = value[i + 1];
    end

    // Pick the slot's move for this cycle
    always_comb begin
      op = CELL_HOLD;
      unique case (cmd.op)
        RING_HOLD:   op = CELL_HOLD;
        RING_LOAD:   op = inside_ring ? CELL_FILL : CELL_CLEAR;
        RING_ROTATE: begin
          if (last_slot) begin
            op = CELL_HEAD;
          end else if (inside_ring) begin
            op = CELL_NEXT;
          end
        end
        RING_REMOVE: begin
          if (last_slot) begin
            op = CELL_CLEAR;
          end else if (inside_ring) begin
            op = CELL_NEXT;
          end
        end
        default:     op = CELL_HOLD;
      endcase
    end

    csre_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .init_value ((i < 64) ? VAL_W'(i + 1) : VAL_W'(0)),
      .fill_value (VAL_W'(i + 1)),
      .next_value (next_value),
      .head_value (value[0]),
      .value      (value[i])
    );
  end

endmodule

// ----- rtl/carousel_shortest_rotation_extract_unit.sv -----
// Carousel extractor: a ring of cells holds the remaining values. A load item
// (mode 0) refills the ring with 1..item_count (capped at MAX_ITEMS) and never raises
// busy; its result strobes on done in the next cycle. An extract item turns
// the ring left one place per cycle, checking the head each cycle, so it is
// busy until the target reaches the head, or until a full turn when it is
// absent; done strobes in the same cycle that busy falls. The reported
// rotations are the shorter way around, not the cycles spent. Each result is
// on result for exactly one cycle with done high and cannot be held off; a
// new start may be given in that same cycle.
// item_count is written through cfg_valid/cfg_ready, accepted whenever the
// block is not busy.
module carousel_shortest_rotation_extract_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  csre_pkg::item_t            item,
  output logic                       done,
  output csre_pkg::result_t          result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [csre_pkg::COUNT_W-1:0] cfg_data
);
  import csre_pkg::*;

  state_t             state, state_next;
  logic [COUNT_W-1:0] item_count;
  logic [VAL_W-1:0]   target, target_next;
  logic [LEN_W-1:0]   length, length_next;
  logic [LEN_W-1:0]   count, count_next;
  logic [TOTAL_W-1:0] total, total_next;
  logic               done_next;
  result_t            result_next;
  ring_cmd_t          ring_cmd;
  logic [VAL_W-1:0]   head_value;

  logic [LEN_W-1:0]   load_len;
  logic [LEN_W-1:0]   back;
  logic               go_right;
  logic [LEN_W-1:0]   turns;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_sat;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= COUNT_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      item_count <= cfg_data;
    end
  end

  // Load count saturates at the ring size
  assign load_len = (item_count > COUNT_W'(MAX_ITEMS)) ? LEN_W'(MAX_ITEMS)
                                                       : LEN_W'(item_count);

  // Shorter way around once the target is at the head
  assign back      = length - count;
  assign go_right  = (count > back);
  assign turns     = go_right ? back : count;
  assign total_sum = {1'b0, total} + (TOTAL_W + 1)'(turns);
  assign total_sat = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

  csre_ring u_ring (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ring_cmd),
    .head_value (head_value)
  );

  // Next state, ring command and result
  always_comb begin
    state_next   = state;
    target_next  = target;
    length_next  = length;
    count_next   = count;
    total_next   = total;
    done_next    = 1'b0;
    result_next  = result;
    ring_cmd.op    = RING_HOLD;
    ring_cmd.bound = length;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (item.mode == MODE_LOAD) begin
            ring_cmd.op    = RING_LOAD;
            ring_cmd.bound = load_len;
            length_next    = load_len;
            total_next     = '0;
            done_next      = 1'b1;
            result_next.found           = 1'b0;
            result_next.rotate_right    = 1'b0;
            result_next.rotations       = '0;
            result_next.total_rotations = '0;
            result_next.remaining       = REMAIN_W'(load_len);
          end else begin
            target_next = item.target_value;
            count_next  = '0;
            state_next  = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        priority if (count == length) begin
          // full turn done without a hit: ring is back where it started
          state_next = ST_IDLE;
          done_next  = 1'b1;
          result_next.found           = 1'b0;
          result_next.rotate_right    = 1'b0;
          result_next.rotations       = '0;
          result_next.total_rotations = total;
          result_next.remaining       = REMAIN_W'(length);
        end else if (head_value == target) begin
          // drop the head and report the shorter turn
          ring_cmd.op = RING_REMOVE;
          length_next = length - LEN_W'(1);
          total_next  = total_sat;
          state_next  = ST_IDLE;
          done_next   = 1'b1;
          result_next.found           = 1'b1;
          result_next.rotate_right    = go_right;
          result_next.rotations       = TURN_W'(turns);
          result_next.total_rotations = total_sat;
          result_next.remaining       = REMAIN_W'(length - LEN_W'(1));
        end else begin
          ring_cmd.op = RING_ROTATE;
          count_next  = count + LEN_W'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      length <= LEN_W'(RESET_LEN);
      total  <= '0;
      count  <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      length <= length_next;
      total  <= total_next;
      count  <= count_next;
      done   <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    target <= target_next;
    result <= result_next;
  end

  // A result only follows an accepted load or the end of a search
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_SEARCH) || ($past(start) && !$past(busy)))
    else $error("done without a finished item");

  // The search never passes the ring length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (count <= length))
    else $error("search count beyond ring length");

  // A removal shortens the ring by exactly one
  a_remove_len: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> ($past(length) == length + LEN_W'(1)))
    else $error("ring length not reduced by one on removal");

  // The turn taken is never more than half the ring
  a_half_turn: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |->
      ((2 * result.rotations) <= (result.remaining + 1)))
    else $error("turn longer than half the ring");

endmodule
